/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the stroke quad generator.
// No dependencies; simulation builds get checks, synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PSKQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pskq assertion failed");
`define PSKQ_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("pskq forbidden condition seen");
`else
`define PSKQ_ASSERT(lbl, clk, rst_n, prop)
`define PSKQ_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* rtl/pskq_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and codes for the polyline stroke quad generator.
// No dependencies.
package pskq_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 24;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ROT_SIN      = 3'd0;
    localparam t_cfg_idx CFG_ROT_COS      = 3'd1;
    localparam t_cfg_idx CFG_STROKE_WIDTH = 3'd2;
    localparam t_cfg_idx CFG_CLOSED_SHAPE = 3'd3;
    localparam t_cfg_idx CFG_COLOR_SLOT   = 3'd4;
    localparam t_cfg_idx CFG_ALPHA_LEVEL  = 3'd5;

    localparam int TRIG_W  = 16;
    localparam int WIDTH_W = 16;
    localparam int COLOR_W = 16;
    localparam int ALPHA_W = 8;

    localparam logic signed [TRIG_W-1:0] ROT_SIN_RST = 16'sd0;
    localparam logic signed [TRIG_W-1:0] ROT_COS_RST = 16'sd16384;
    localparam logic [WIDTH_W-1:0]       WIDTH_RST   = 16'd256;
    localparam logic                     CLOSED_RST  = 1'b1;
    localparam logic [COLOR_W-1:0]       COLOR_RST   = 16'd0;
    localparam logic [ALPHA_W-1:0]       ALPHA_RST   = 8'd255;

    // Q1.14 rotation
    localparam int ROT_FRAC = 14;
    localparam int ROT_HALF = 8192;

    // segment vector is scaled so its larger component sits in [2^29, 2^30)
    localparam int NORM_BITS = 30;
    localparam int SQ_W      = 2 * NORM_BITS + 2;
    localparam int LEN_W     = SQ_W / 2;
    localparam int ONUM_W    = NORM_BITS + WIDTH_W + 1;
    localparam int OFS_W     = WIDTH_W + 2;
    localparam int MUL_B_W   = NORM_BITS + 1;

endpackage

/* rtl/pskq_point_mem.sv */
`timescale 1ns / 1ps
// Point store: one write port, one registered read port, x and y side by side.
// Uses pskq_pkg for default sizes.
module pskq_point_mem #(
    parameter int DEPTH = pskq_pkg::MAX_POINTS_DEF,
    parameter int W     = pskq_pkg::COORD_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wx,
    input  logic [W-1:0]  i_wy,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rx,
    output logic [W-1:0]  o_ry
);

    logic [2*W-1:0] r_mem [DEPTH];
    logic [2*W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wy, i_wx};
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rx = r_rd[W-1:0];
    assign o_ry = r_rd[2*W-1:W];

endmodule

/* rtl/pskq_divider.sv */
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module pskq_divider #(
    parameter int NUMW = 47,
    parameter int DENW = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [NUMW-1:0] i_num,
    input  logic [DENW-1:0] i_den,
    output logic            o_done,
    output logic [NUMW-1:0] o_quo,
    output logic [DENW-1:0] o_rem
);

    localparam int CW = $clog2(NUMW + 1);

    logic [NUMW-1:0] r_num;
    logic [DENW-1:0] r_den;
    logic [DENW-1:0] r_rem;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [DENW:0]   rem_sh;
    logic            qbit;
    logic [DENW:0]   rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_num[NUMW-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        qbit    = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CW'(NUMW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[NUMW-2:0], qbit};
                r_rem <= qbit ? rem_sub[DENW-1:0] : rem_sh[DENW-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
    assign o_rem  = r_rem;

endmodule

/* rtl/pskq_isqrt.sv */
`timescale 1ns / 1ps
// Integer square root (floor), two radicand bits per cycle.
// No dependencies.
module pskq_isqrt #(
    parameter int IW = 62
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [IW-1:0]     i_val,
    output logic              o_done,
    output logic [IW/2-1:0]   o_root
);

    localparam int STEPS = IW / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [IW-1:0] r_v;
    logic [IW-1:0] r_res;
    logic [IW-1:0] r_bit;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [IW-1:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v    <= i_val;
                r_res  <= '0;
                r_bit  <= IW'(1) << (IW - 2);
                r_cnt  <= CW'(STEPS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_v >= trial) begin
                    r_v   <= r_v - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[IW/2-1:0];

endmodule

/* rtl/polyline_stroke_quad_generator.sv */
`timescale 1ns / 1ps
// Polyline stroke quad generator: point loader, sequencer, shared multiplier.
// Depends on pskq_pkg, pskq_point_mem, pskq_divider, pskq_isqrt, assert_macros.svh.
//
// Usage: points arrive one word per cycle on the input channel; the word with
// i_final_point set closes the polygon. Points past MAX_POINTS are dropped.
// After a final point, with two or more points and nonzero alpha, the block
// stops taking input and emits one quad word per segment (plus the closing
// segment when closed) on the output channel; last_segment marks the final one.
// Loading is one point per cycle. After a final point the centre takes two
// divides, then each segment takes the rotation on the shared multiplier,
// normalizing, the square root and two serial divides.
// Reset (synchronous, active low) restores the register defaults and empties
// the point count and sums; the point store itself is not cleared.
// A stalled receiver holds the current word in the output register; work on the
// next segment goes on and waits only when its word is ready to be loaded.
// Configuration writes are always taken and must be issued while idle.
`include "assert_macros.svh"
module polyline_stroke_quad_generator #(
    parameter int MAX_POINTS = pskq_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = pskq_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  pskq_pkg::t_cfg_idx                    i_cfg_index,
    input  logic [pskq_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // points in
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [COORD_BITS-1:0]          i_point_x,
    input  logic signed [COORD_BITS-1:0]          i_point_y,
    input  logic                                  i_final_point,
    // quads out
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [COORD_BITS-1:0]          o_corner_a_x,
    output logic signed [COORD_BITS-1:0]          o_corner_a_y,
    output logic signed [COORD_BITS-1:0]          o_corner_b_x,
    output logic signed [COORD_BITS-1:0]          o_corner_b_y,
    output logic signed [COORD_BITS-1:0]          o_corner_c_x,
    output logic signed [COORD_BITS-1:0]          o_corner_c_y,
    output logic signed [COORD_BITS-1:0]          o_corner_d_x,
    output logic signed [COORD_BITS-1:0]          o_corner_d_y,
    output logic [pskq_pkg::COLOR_W-1:0]          o_segment_color,
    output logic                                  o_last_segment
);

    localparam int CB     = COORD_BITS;
    localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SW     = CB + AW;
    localparam int AV_W   = SW + 2;
    localparam int LW     = CB + 1;
    localparam int P      = CB + 4;
    localparam int DW     = P + 1;
    localparam int MW     = DW - 1;
    localparam int NB     = pskq_pkg::NORM_BITS;
    localparam int NW     = (MW > NB) ? MW : NB;
    localparam int MA     = (LW > NB + 1) ? LW : NB + 1;
    localparam int MB     = pskq_pkg::MUL_B_W;
    localparam int PRW    = MA + MB;
    localparam int RW     = CB + 19;
    localparam int SQW    = pskq_pkg::SQ_W;
    localparam int LENW   = pskq_pkg::LEN_W;
    localparam int ONW    = pskq_pkg::ONUM_W;
    localparam int NUMW   = (AV_W > ONW) ? AV_W : ONW;
    localparam int DENW   = LENW + 1;
    localparam int OW     = pskq_pkg::OFS_W;
    localparam int TW     = pskq_pkg::TRIG_W;
    localparam int WW     = pskq_pkg::WIDTH_W;

    localparam logic signed [P:0] SAT_HI = (P+1)'((64'sd1 <<< (CB - 1)) - 64'sd1);
    localparam logic signed [P:0] SAT_LO = -SAT_HI - (P+1)'(1);

    typedef enum logic [3:0] {
        ST_LOAD, ST_CDIV, ST_CWAIT, ST_RD, ST_LAT, ST_ROT, ST_NEXT, ST_DIFF,
        ST_NORM, ST_SQ, ST_SQRT_GO, ST_SQRT_WAIT, ST_OMUL, ST_ODIV, ST_OWAIT, ST_EMIT
    } t_state;

    function automatic logic signed [CB-1:0] sat(input logic signed [P:0] v);
        logic signed [P:0] c;
        c = v;
        if (v > SAT_HI) c = SAT_HI;
        if (v < SAT_LO) c = SAT_LO;
        return c[CB-1:0];
    endfunction

    t_state r_state;

    // configuration registers
    logic signed [TW-1:0]            r_rot_sin;
    logic signed [TW-1:0]            r_rot_cos;
    logic [WW-1:0]                   r_stroke_width;
    logic                            r_closed;
    logic [pskq_pkg::COLOR_W-1:0]    r_color;
    logic [pskq_pkg::ALPHA_W-1:0]    r_alpha;

    // sequencer state
    logic [CNT_W-1:0]                r_cnt;
    logic signed [SW-1:0]            r_sum_x;
    logic signed [SW-1:0]            r_sum_y;
    logic signed [CB-1:0]            r_cx;
    logic signed [CB-1:0]            r_cy;
    logic                            r_axis;
    logic [CNT_W-1:0]                r_seg;
    logic [AW-1:0]                   r_rd_idx;
    logic                            r_init;
    logic [2:0]                      r_step;
    logic signed [LW-1:0]            r_lx;
    logic signed [LW-1:0]            r_ly;
    logic signed [PRW-1:0]           r_prod;
    logic signed [RW-1:0]            r_acc;
    logic signed [P-1:0]             r_rx;
    logic signed [P-1:0]             r_p0x;
    logic signed [P-1:0]             r_p0y;
    logic signed [P-1:0]             r_p1x;
    logic signed [P-1:0]             r_p1y;
    logic signed [P-1:0]             r_fx;
    logic signed [P-1:0]             r_fy;
    logic [NW-1:0]                   r_ux;
    logic [NW-1:0]                   r_uy;
    logic                            r_nx;
    logic                            r_ny;
    logic [SQW-1:0]                  r_ss;
    logic [LENW-1:0]                 r_len;
    logic [NUMW-1:0]                 r_onum;
    logic signed [OW-1:0]            r_ox;
    logic signed [OW-1:0]            r_oy;

    // output register
    logic                            r_out_valid;
    logic signed [CB-1:0]            r_ax, r_ay, r_bx, r_by, r_cx_o, r_cy_o, r_dx, r_dy;
    logic [pskq_pkg::COLOR_W-1:0]    r_out_color;
    logic                            r_out_last;

    // combinational helpers
    logic                            in_acc;
    logic                            has_room;
    logic [CNT_W-1:0]                cnt_inc;
    logic [CB-1:0]                   mem_rx, mem_ry;
    logic signed [SW-1:0]            c_sum;
    logic signed [AV_W-1:0]          c_av;
    logic                            c_neg;
    logic [AV_W-1:0]                 c_mag;
    logic signed [CB+1:0]            c_val;
    logic                            div_start, div_done;
    logic [NUMW-1:0]                 div_num, div_quo;
    logic [DENW-1:0]                 div_den, div_rem;
    logic                            sq_start, sq_done;
    logic [LENW-1:0]                 sq_root;
    logic signed [MA-1:0]            mul_a;
    logic signed [MB-1:0]            mul_b;
    logic signed [RW-1:0]            rot_sum;
    logic signed [P-1:0]             rot_res;
    logic signed [DW-1:0]            dx, dy;
    logic [MW-1:0]                   mag_x, mag_y;
    logic [NW-1:0]                   mx;
    logic [OW-2:0]                   oq;
    logic                            o_neg;
    logic signed [OW-1:0]            o_val;
    logic [CNT_W-1:0]                segs;
    logic [CNT_W-1:0]                seg_nxt;
    logic                            out_load, out_last;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_LOAD);
    assign in_acc      = i_in_valid && o_in_ready;
    assign has_room    = (r_cnt < CNT_W'(MAX_POINTS));
    assign cnt_inc     = has_room ? r_cnt + 1'b1 : r_cnt;

    pskq_point_mem #(.DEPTH(MAX_POINTS), .W(CB), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (in_acc && has_room),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wx    (i_point_x),
        .i_wy    (i_point_y),
        .i_raddr (r_rd_idx),
        .o_rx    (mem_rx),
        .o_ry    (mem_ry)
    );

    // centre = floor((2*sum + n) / (2*n))
    always_comb begin
        c_sum = r_axis ? r_sum_y : r_sum_x;
        c_av  = (AV_W'(c_sum) <<< 1) + AV_W'(signed'({1'b0, r_cnt}));
        c_neg = c_av[AV_W-1];
        c_mag = c_neg ? AV_W'(-c_av) : AV_W'(c_av);
        c_val = signed'({1'b0, div_quo[CB:0]});
        if (c_neg) begin
            c_val = -c_val - (CB+2)'(|div_rem);
        end
    end

    assign div_start = (r_state == ST_CDIV) || (r_state == ST_ODIV);
    assign div_num   = (r_state == ST_ODIV) ? r_onum : NUMW'(c_mag);
    assign div_den   = (r_state == ST_ODIV) ? {r_len, 1'b0} : DENW'({r_cnt, 1'b0});

    pskq_divider #(.NUMW(NUMW), .DENW(DENW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign sq_start = (r_state == ST_SQRT_GO);

    pskq_isqrt #(.IW(SQW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (r_ss),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_ROT: begin
                mul_a = (r_step == 3'd0 || r_step == 3'd2) ? MA'(r_lx) : MA'(r_ly);
                mul_b = (r_step == 3'd0 || r_step == 3'd3) ? MB'(r_rot_cos) : MB'(r_rot_sin);
            end
            ST_SQ: begin
                if (r_step == 3'd0) begin
                    mul_a = MA'(signed'({1'b0, r_ux[NB-1:0]}));
                    mul_b = MB'(signed'({1'b0, r_ux[NB-1:0]}));
                end else begin
                    mul_a = MA'(signed'({1'b0, r_uy[NB-1:0]}));
                    mul_b = MB'(signed'({1'b0, r_uy[NB-1:0]}));
                end
            end
            ST_OMUL: begin
                mul_a = r_axis ? MA'(signed'({1'b0, r_ux[NB-1:0]}))
                               : MA'(signed'({1'b0, r_uy[NB-1:0]}));
                mul_b = MB'(signed'({1'b0, r_stroke_width}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        rot_sum = (r_step == 3'd2) ? r_acc - RW'(r_prod) : r_acc + RW'(r_prod);
        rot_res = P'(rot_sum >>> pskq_pkg::ROT_FRAC)
                + ((r_step == 3'd2) ? P'(r_cx) : P'(r_cy));
    end

    always_comb begin
        dx    = DW'(r_p1x) - DW'(r_p0x);
        dy    = DW'(r_p1y) - DW'(r_p0y);
        mag_x = dx[DW-1] ? MW'(-dx) : MW'(dx);
        mag_y = dy[DW-1] ? MW'(-dy) : MW'(dy);
        mx    = (r_ux > r_uy) ? r_ux : r_uy;
    end

    always_comb begin
        oq    = div_quo[OW-2:0];
        o_neg = r_axis ? r_nx : (!r_ny && (r_uy != '0));
        o_val = o_neg ? -signed'({1'b0, oq}) : signed'({1'b0, oq});
    end

    assign segs     = r_closed ? r_cnt : r_cnt - 1'b1;
    assign seg_nxt  = r_seg + 1'b1;
    assign out_load = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);
    assign out_last = (seg_nxt == segs);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_sin      <= pskq_pkg::ROT_SIN_RST;
            r_rot_cos      <= pskq_pkg::ROT_COS_RST;
            r_stroke_width <= pskq_pkg::WIDTH_RST;
            r_closed       <= pskq_pkg::CLOSED_RST;
            r_color        <= pskq_pkg::COLOR_RST;
            r_alpha        <= pskq_pkg::ALPHA_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pskq_pkg::CFG_ROT_SIN:      r_rot_sin      <= signed'(i_cfg_data[TW-1:0]);
                pskq_pkg::CFG_ROT_COS:      r_rot_cos      <= signed'(i_cfg_data[TW-1:0]);
                pskq_pkg::CFG_STROKE_WIDTH: r_stroke_width <= i_cfg_data[WW-1:0];
                pskq_pkg::CFG_CLOSED_SHAPE: r_closed       <= i_cfg_data[0];
                pskq_pkg::CFG_COLOR_SLOT:   r_color        <= i_cfg_data[pskq_pkg::COLOR_W-1:0];
                pskq_pkg::CFG_ALPHA_LEVEL:  r_alpha        <= i_cfg_data[pskq_pkg::ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_cnt       <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_seg       <= '0;
            r_step      <= '0;
            r_axis      <= 1'b0;
            r_init      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // a word loaded this cycle keeps valid high
            if (r_out_valid && i_out_ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (in_acc) begin
                        if (i_final_point) begin
                            if (cnt_inc >= CNT_W'(2) && r_alpha != '0) begin
                                r_cnt  <= cnt_inc;
                                r_axis <= 1'b0;
                                r_seg  <= '0;
                                if (has_room) begin
                                    r_sum_x <= r_sum_x + SW'(i_point_x);
                                    r_sum_y <= r_sum_y + SW'(i_point_y);
                                end
                                r_state <= ST_CDIV;
                            end else begin
                                r_cnt   <= '0;
                                r_sum_x <= '0;
                                r_sum_y <= '0;
                            end
                        end else if (has_room) begin
                            r_cnt   <= cnt_inc;
                            r_sum_x <= r_sum_x + SW'(i_point_x);
                            r_sum_y <= r_sum_y + SW'(i_point_y);
                        end
                    end
                end
                ST_CDIV: r_state <= ST_CWAIT;
                ST_CWAIT: begin
                    if (div_done) begin
                        if (!r_axis) begin
                            r_cx    <= c_val[CB-1:0];
                            r_axis  <= 1'b1;
                            r_state <= ST_CDIV;
                        end else begin
                            r_cy     <= c_val[CB-1:0];
                            r_init   <= 1'b1;
                            r_rd_idx <= '0;
                            r_state  <= ST_RD;
                        end
                    end
                end
                ST_RD: r_state <= ST_LAT;
                ST_LAT: begin
                    r_lx    <= LW'(signed'(mem_rx)) - LW'(r_cx);
                    r_ly    <= LW'(signed'(mem_ry)) - LW'(r_cy);
                    r_step  <= '0;
                    r_state <= ST_ROT;
                end
                ST_ROT: begin
                    // products of the shared multiplier are registered, so they land in the following cycle
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        3'd1, 3'd3: r_acc <= RW'(r_prod) + RW'(pskq_pkg::ROT_HALF);
                        3'd2:       r_rx  <= rot_res;
                        3'd4: begin
                            if (r_init) begin
                                r_p0x   <= r_rx;
                                r_p0y   <= rot_res;
                                r_fx    <= r_rx;
                                r_fy    <= rot_res;
                                r_init  <= 1'b0;
                                r_state <= ST_NEXT;
                            end else begin
                                r_p1x   <= r_rx;
                                r_p1y   <= rot_res;
                                r_state <= ST_DIFF;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_NEXT: begin
                    if (seg_nxt == r_cnt) begin
                        // closing segment reuses the first rotated point
                        r_p1x   <= r_fx;
                        r_p1y   <= r_fy;
                        r_state <= ST_DIFF;
                    end else begin
                        r_rd_idx <= seg_nxt[AW-1:0];
                        r_state  <= ST_RD;
                    end
                end
                ST_DIFF: begin
                    r_ux <= NW'(mag_x);
                    r_uy <= NW'(mag_y);
                    r_nx <= dx[DW-1];
                    r_ny <= dy[DW-1];
                    if (dx == '0 && dy == '0) begin
                        r_ox    <= '0;
                        r_oy    <= '0;
                        r_state <= ST_EMIT;
                    end else begin
                        r_state <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    if ((mx >> NB) != '0) begin
                        r_ux <= r_ux >> 1;
                        r_uy <= r_uy >> 1;
                    end else if ((mx >> (NB - 1)) == '0) begin
                        r_ux <= r_ux << 1;
                        r_uy <= r_uy << 1;
                    end else begin
                        r_step  <= '0;
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd1) begin
                        r_ss <= SQW'(r_prod);
                    end else if (r_step == 3'd2) begin
                        r_ss    <= r_ss + SQW'(r_prod);
                        r_state <= ST_SQRT_GO;
                    end
                end
                ST_SQRT_GO: r_state <= ST_SQRT_WAIT;
                ST_SQRT_WAIT: begin
                    if (sq_done) begin
                        r_len   <= sq_root;
                        r_axis  <= 1'b0;
                        r_step  <= '0;
                        r_state <= ST_OMUL;
                    end
                end
                ST_OMUL: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd1) begin
                        r_onum  <= NUMW'(r_prod[ONW-1:0]) + NUMW'(r_len);
                        r_state <= ST_ODIV;
                    end
                end
                ST_ODIV: r_state <= ST_OWAIT;
                ST_OWAIT: begin
                    if (div_done) begin
                        if (!r_axis) begin
                            r_ox    <= o_val;
                            r_axis  <= 1'b1;
                            r_step  <= '0;
                            r_state <= ST_OMUL;
                        end else begin
                            r_oy    <= o_val;
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_ax        <= sat((P+1)'(r_p0x) + (P+1)'(r_ox));
                        r_ay        <= sat((P+1)'(r_p0y) + (P+1)'(r_oy));
                        r_bx        <= sat((P+1)'(r_p0x) - (P+1)'(r_ox));
                        r_by        <= sat((P+1)'(r_p0y) - (P+1)'(r_oy));
                        r_cx_o      <= sat((P+1)'(r_p1x) + (P+1)'(r_ox));
                        r_cy_o      <= sat((P+1)'(r_p1y) + (P+1)'(r_oy));
                        r_dx        <= sat((P+1)'(r_p1x) - (P+1)'(r_ox));
                        r_dy        <= sat((P+1)'(r_p1y) - (P+1)'(r_oy));
                        r_out_color <= r_color;
                        r_out_last  <= out_last;
                        if (out_last) begin
                            r_cnt   <= '0;
                            r_sum_x <= '0;
                            r_sum_y <= '0;
                            r_state <= ST_LOAD;
                        end else begin
                            r_seg   <= seg_nxt;
                            r_p0x   <= r_p1x;
                            r_p0y   <= r_p1y;
                            r_state <= ST_NEXT;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_corner_a_x    = r_ax;
    assign o_corner_a_y    = r_ay;
    assign o_corner_b_x    = r_bx;
    assign o_corner_b_y    = r_by;
    assign o_corner_c_x    = r_cx_o;
    assign o_corner_c_y    = r_cy_o;
    assign o_corner_d_x    = r_dx;
    assign o_corner_d_y    = r_dy;
    assign o_segment_color = r_out_color;
    assign o_last_segment  = r_out_last;

    `PSKQ_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt > CNT_W'(MAX_POINTS))
    `PSKQ_ASSERT(a_seg_range, i_clk, i_rst_n, (r_state != ST_LOAD) |-> (r_seg < r_cnt))
    `PSKQ_ASSERT(a_div_owner, i_clk, i_rst_n, div_done |-> (r_state == ST_CWAIT || r_state == ST_OWAIT))
    `PSKQ_ASSERT(a_last_idle, i_clk, i_rst_n, (out_load && out_last) |=> o_in_ready)

endmodule

/* tb/sv/polyline_stroke_quad_generator_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for polyline_stroke_quad_generator: directed table plus
// random polygons under several register settings. Depends on pskq_pkg and the RTL.
module polyline_stroke_quad_generator_tb;

    localparam int NPTS = 64;
    localparam int CB = 24;
    localparam longint CMAX = (64'sd1 <<< (CB - 1)) - 1;
    localparam longint CMIN = -(64'sd1 <<< (CB - 1));
    localparam int SETTLE = 800;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic signed [CB-1:0]           ax, ay, bx, by, cx, cy, dx, dy;
        logic [pskq_pkg::COLOR_W-1:0]   color;
        logic                           last;
    } t_quad;

    typedef struct {
        int x;
        int y;
        bit fin;
        bit typed;
    } t_step;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    pskq_pkg::t_cfg_idx i_cfg_index = pskq_pkg::CFG_ROT_SIN;
    logic [pskq_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic signed [CB-1:0] i_point_x = '0;
    logic signed [CB-1:0] i_point_y = '0;
    logic i_final_point = 1'b0;
    logic i_out_ready = 1'b0;
    logic o_cfg_ready, o_in_ready, o_out_valid, o_last_segment;
    logic signed [CB-1:0] o_corner_a_x, o_corner_a_y, o_corner_b_x, o_corner_b_y;
    logic signed [CB-1:0] o_corner_c_x, o_corner_c_y, o_corner_d_x, o_corner_d_y;
    logic [pskq_pkg::COLOR_W-1:0] o_segment_color;

    polyline_stroke_quad_generator dut (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // shadow of the block
    longint pt_x[NPTS];
    longint pt_y[NPTS];
    int n_pts = 0;
    longint acc_x = 0, acc_y = 0;
    longint r_sin = 0, r_cos = 16384, r_width = 256;
    bit r_closed = 1'b1;
    logic [pskq_pkg::COLOR_W-1:0] r_color = '0;
    logic [pskq_pkg::ALPHA_W-1:0] r_alpha = 8'd255;

    t_quad expected_quads[$];
    t_quad typed_quads[$];
    int errors = 0;
    bit idle_en = 1'b1;
    int items = 0;

    function automatic longint fdiv(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [CB-1:0] clamp(longint v);
        if (v > CMAX) v = CMAX;
        if (v < CMIN) v = CMIN;
        return v[CB-1:0];
    endfunction

    function automatic longint half_width_round(bit neg, longint unsigned mag,
                                                longint unsigned len);
        longint unsigned q;
        q = (mag + len) / (2 * len);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // perpendicular offset of one segment, scaled by half the stroke width
    task automatic stroke_normal(longint vx, longint vy, output longint ox, output longint oy);
        longint unsigned ux, uy, mx, len;
        ux = (vx < 0) ? -vx : vx;
        uy = (vy < 0) ? -vy : vy;
        mx = (ux > uy) ? ux : uy;
        if (mx == 0) begin
            ox = 0;
            oy = 0;
            return;
        end
        while (mx >= (64'd1 << 30)) begin
            ux >>= 1; uy >>= 1; mx >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            ux <<= 1; uy <<= 1; mx <<= 1;
        end
        len = int_sqrt(ux * ux + uy * uy);
        ox = half_width_round(!(vy < 0) && uy != 0, uy * r_width, len);
        oy = half_width_round(vx < 0, ux * r_width, len);
    endtask

    // one accepted point word; a final point turns the polygon into quads
    task automatic take_point(longint x, longint y, bit fin, bit keep);
        longint cxm, cym, l0x, l0y, l1x, l1y, p0x, p0y, p1x, p1y, ox, oy;
        int segs, j;
        t_quad q;
        if (n_pts < NPTS) begin
            pt_x[n_pts] = x;
            pt_y[n_pts] = y;
            acc_x += x;
            acc_y += y;
            n_pts++;
        end
        if (!fin) return;
        if (n_pts >= 2 && r_alpha != 0) begin
            cxm = fdiv(2 * acc_x + n_pts, 2 * n_pts);
            cym = fdiv(2 * acc_y + n_pts, 2 * n_pts);
            segs = r_closed ? n_pts : n_pts - 1;
            for (int i = 0; i < segs; i++) begin
                j = (i + 1 == n_pts) ? 0 : i + 1;
                l0x = pt_x[i] - cxm; l0y = pt_y[i] - cym;
                l1x = pt_x[j] - cxm; l1y = pt_y[j] - cym;
                p0x = cxm + fdiv(l0x * r_cos - l0y * r_sin + pskq_pkg::ROT_HALF, 16384);
                p0y = cym + fdiv(l0x * r_sin + l0y * r_cos + pskq_pkg::ROT_HALF, 16384);
                p1x = cxm + fdiv(l1x * r_cos - l1y * r_sin + pskq_pkg::ROT_HALF, 16384);
                p1y = cym + fdiv(l1x * r_sin + l1y * r_cos + pskq_pkg::ROT_HALF, 16384);
                stroke_normal(p1x - p0x, p1y - p0y, ox, oy);
                q.ax = clamp(p0x + ox); q.ay = clamp(p0y + oy);
                q.bx = clamp(p0x - ox); q.by = clamp(p0y - oy);
                q.cx = clamp(p1x + ox); q.cy = clamp(p1y + oy);
                q.dx = clamp(p1x - ox); q.dy = clamp(p1y - oy);
                q.color = r_color;
                q.last = (i + 1 == segs);
                if (keep) expected_quads.push_back(q);
            end
        end
        n_pts = 0;
        acc_x = 0;
        acc_y = 0;
    endtask

    task automatic send_point(longint x, longint y, bit fin, bit keep);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_point_x <= x[CB-1:0];
        i_point_y <= y[CB-1:0];
        i_final_point <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        take_point(x, y, fin, keep);
        items++;
    endtask

    task automatic write_reg(pskq_pkg::t_cfg_idx idx, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[pskq_pkg::CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            pskq_pkg::CFG_ROT_SIN:      r_sin = longint'($signed(value[15:0]));
            pskq_pkg::CFG_ROT_COS:      r_cos = longint'($signed(value[15:0]));
            pskq_pkg::CFG_STROKE_WIDTH: r_width = value[15:0];
            pskq_pkg::CFG_CLOSED_SHAPE: r_closed = value[0];
            pskq_pkg::CFG_COLOR_SLOT:   r_color = value[15:0];
            pskq_pkg::CFG_ALPHA_LEVEL:  r_alpha = value[7:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_quads.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic longint rand_coord();
        case ($urandom_range(0, 3))
            0: return longint'($signed(24'($urandom)));
            1: return longint'($urandom_range(0, 4095)) - 2048;
            2: return $urandom_range(0, 1) ? CMAX : CMIN;
            default: return longint'($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    task automatic random_polygon(int count);
        longint x, y;
        x = rand_coord();
        y = rand_coord();
        for (int k = 0; k < count; k++) begin
            // repeated point now and then gives a zero-length segment
            if (k == 0 || $urandom_range(0, 7) != 0) begin
                x = rand_coord();
                y = rand_coord();
            end
            send_point(x, y, k == count - 1, 1'b1);
        end
    endtask

    // output side: random stall bursts while idling is on
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!idle_en) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 10);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_quad got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_corner_a_x, o_corner_a_y, o_corner_b_x, o_corner_b_y,
                    o_corner_c_x, o_corner_c_y, o_corner_d_x, o_corner_d_y,
                    o_segment_color, o_last_segment};
            if (expected_quads.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected quad word %p", got);
            end else begin
                want = expected_quads.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("quad mismatch\n  exp %p\n  got %p", want, got);
                end
            end
        end
    end

    int quiet = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (i_cfg_valid && o_cfg_ready)
                || (o_out_valid && i_out_ready)) begin
            quiet <= 0;
        end else if (quiet == WATCHDOG) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG);
            $display("polyline_stroke_quad_generator regression: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    t_step plan[$];

    initial begin
        // default registers: stroke width 256, no rotation, closed
        plan = '{
            '{0, 0, 0, 1}, '{256, 0, 1, 1},
            '{77, -5, 1, 0},
            '{8388607, 8388607, 0, 0}, '{-8388608, -8388608, 0, 0},
            '{8388607, -8388608, 1, 0},
            '{5, 5, 0, 0}, '{5, 5, 0, 0}, '{100, -3, 1, 0},
            '{8388607, 0, 0, 0}, '{-8388608, 0, 0, 0}, '{0, 8388607, 0, 0},
            '{0, -8388608, 1, 0},
            '{-1, -1, 0, 0}, '{1, 1, 0, 0}, '{-300, 700, 1, 0},
            '{123456, -654321, 0, 0}, '{-2, 3, 1, 0}
        };
        typed_quads = '{
            '{24'sd0, 24'sd128, 24'sd0, -24'sd128,
              24'sd256, 24'sd128, 24'sd256, -24'sd128, 16'd0, 1'b0},
            '{24'sd256, -24'sd128, 24'sd256, 24'sd128,
              24'sd0, -24'sd128, 24'sd0, 24'sd128, 16'd0, 1'b1}
        };
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            send_point(plan[r].x, plan[r].y, plan[r].fin, !plan[r].typed);
            if (plan[r].typed && plan[r].fin) begin
                foreach (typed_quads[t]) expected_quads.push_back(typed_quads[t]);
            end
        end
        drain();

        items = 0;
        for (int ph = 0; ph < 8; ph++) begin
            idle_en = (ph != 3 && ph != 7);
            case (ph)
                0: begin
                    write_reg(pskq_pkg::CFG_ROT_SIN, 0);
                    write_reg(pskq_pkg::CFG_ROT_COS, 16384);
                    write_reg(pskq_pkg::CFG_STROKE_WIDTH, 256);
                    write_reg(pskq_pkg::CFG_CLOSED_SHAPE, 1);
                    write_reg(pskq_pkg::CFG_COLOR_SLOT, 0);
                    write_reg(pskq_pkg::CFG_ALPHA_LEVEL, 255);
                end
                1: write_reg(pskq_pkg::CFG_ALPHA_LEVEL, 0);
                2: begin
                    write_reg(pskq_pkg::CFG_ALPHA_LEVEL, 1);
                    write_reg(pskq_pkg::CFG_CLOSED_SHAPE, 0);
                    write_reg(pskq_pkg::CFG_STROKE_WIDTH, 65535);
                    write_reg(pskq_pkg::CFG_COLOR_SLOT, 65535);
                    write_reg(pskq_pkg::CFG_ROT_SIN, 16384);
                    write_reg(pskq_pkg::CFG_ROT_COS, 0);
                end
                3: begin
                    write_reg(pskq_pkg::CFG_STROKE_WIDTH, 0);
                    write_reg(pskq_pkg::CFG_CLOSED_SHAPE, 1);
                    write_reg(pskq_pkg::CFG_ROT_SIN, -16384);
                    write_reg(pskq_pkg::CFG_ROT_COS, -16384);
                end
                default: begin
                    write_reg(pskq_pkg::CFG_ROT_SIN, int'($urandom_range(0, 32768)) - 16384);
                    write_reg(pskq_pkg::CFG_ROT_COS, int'($urandom_range(0, 32768)) - 16384);
                    write_reg(pskq_pkg::CFG_STROKE_WIDTH, $urandom_range(0, 65535));
                    write_reg(pskq_pkg::CFG_CLOSED_SHAPE, $urandom_range(0, 1));
                    write_reg(pskq_pkg::CFG_COLOR_SLOT, $urandom_range(0, 65535));
                    write_reg(pskq_pkg::CFG_ALPHA_LEVEL, $urandom_range(1, 255));
                end
            endcase
            // store overflow: more points than the store holds
            if (ph == 5) random_polygon(67);
            while (items < (ph + 1) * 27) random_polygon($urandom_range(1, 8));
            drain();
        end

        if (errors == 0 && expected_quads.size() == 0) begin
            $display("polyline_stroke_quad_generator regression: pass");
        end else begin
            $display("polyline_stroke_quad_generator regression: fail");
        end
        $finish;
    end
endmodule
